[rtl/core/sfp_pkg.sv]
// Shared types, constants and the CRC16 byte update for the serial frame parser.
package sfp_pkg;

    // Default size of the payload buffer in bytes.
    localparam int SFP_MAX_PAYLOAD = 64;

    // Frame marker bytes and CRC constants.
    localparam logic [7:0]  SYNC1_BYTE = 8'h55;
    localparam logic [7:0]  SYNC2_BYTE = 8'hAA;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Widths of the result stream.
    localparam int TDATA_W = 24;
    localparam int PLEN_W  = 7;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_CMD   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRCL  = 3'd5,
        PH_CRCH  = 3'd6
    } parse_phase_t;

    // Result emitter states.
    typedef enum logic [1:0] {
        E_IDLE = 2'd0,
        E_READ = 2'd1,
        E_SHOW = 2'd2
    } emit_state_t;

    // Handoff of a checked frame from the parser to the emitter.
    typedef struct packed {
        logic       start;
        logic [7:0] command;
        logic [7:0] length;
    } frame_info_t;

    // One byte of the reflected Modbus CRC16, eight shift steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[rtl/core/sfp_payload_ram.sv]
// Payload byte buffer: one write port and one registered read port.
module sfp_payload_ram
    import sfp_pkg::*;
#(
    parameter int DEPTH  = SFP_MAX_PAYLOAD,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    // Write side.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read side, registered.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/sfp_parser.sv]
// Byte-serial frame parser: sync search, length check, CRC16 and payload capture.
module sfp_parser
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = SFP_MAX_PAYLOAD,
    parameter int LEN_W       = 7,
    parameter int ADDR_W      = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [7:0]        rx_byte,
    output frame_info_t       frame_info,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [7:0]        ram_wdata
);

    localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

    parse_phase_t     phase_reg, phase_next;
    logic [LEN_W-1:0] frame_length_reg, frame_length_next;
    logic [7:0]       command_reg, command_next;
    logic [LEN_W-1:0] fill_count_reg, fill_count_next;
    logic [7:0]       crc_low_reg, crc_low_next;
    logic [15:0]      crc_reg, crc_next;

    logic [15:0]      crc_fed;
    logic [LEN_W-1:0] fill_inc;
    logic             len_too_big;
    logic             crc_match;
    logic             frame_start;

    assign crc_fed     = crc_feed(crc_reg, rx_byte);
    assign fill_inc    = fill_count_reg + LEN_W'(1);
    assign len_too_big = {1'b0, rx_byte} > MaxLen;
    assign crc_match   = {rx_byte, crc_low_reg} == crc_reg;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (byte_accept) begin
            case (phase_reg)
                PH_SYNC2: begin
                    if (rx_byte == SYNC2_BYTE) begin
                        phase_next = PH_LEN;
                    end else if (rx_byte != SYNC1_BYTE) begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_LEN: begin
                    phase_next = len_too_big ? PH_SYNC1 : PH_CMD;
                end
                PH_CMD: begin
                    phase_next = (frame_length_reg == '0) ? PH_CRCL : PH_DATA;
                end
                PH_DATA: begin
                    if (fill_inc >= frame_length_reg) begin
                        phase_next = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    phase_next = PH_CRCH;
                end
                PH_CRCH: begin
                    phase_next = PH_SYNC1;
                end
                default: begin
                    phase_next = (rx_byte == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    // Frame fields, CRC, buffer writes and the handoff pulse.
    always_comb begin
        frame_length_next = frame_length_reg;
        command_next      = command_reg;
        fill_count_next   = fill_count_reg;
        crc_low_next      = crc_low_reg;
        crc_next          = crc_reg;
        ram_we            = 1'b0;
        frame_start       = 1'b0;
        if (byte_accept) begin
            case (phase_reg)
                PH_SYNC2: begin
                end
                PH_LEN: begin
                    if (!len_too_big) begin
                        frame_length_next = rx_byte[LEN_W-1:0];
                        crc_next          = crc_fed;
                    end
                end
                PH_CMD: begin
                    command_next = rx_byte;
                    crc_next     = crc_fed;
                end
                PH_DATA: begin
                    ram_we          = 1'b1;
                    fill_count_next = fill_inc;
                    crc_next        = crc_fed;
                end
                PH_CRCL: begin
                    crc_low_next = rx_byte;
                end
                PH_CRCH: begin
                    frame_start = crc_match;
                end
                default: begin
                    frame_length_next = '0;
                    command_next      = '0;
                    fill_count_next   = '0;
                    crc_low_next      = '0;
                    crc_next          = CRC_INIT;
                end
            endcase
        end
    end

    assign ram_waddr          = fill_count_reg[ADDR_W-1:0];
    assign ram_wdata          = rx_byte;
    assign frame_info.start   = frame_start;
    assign frame_info.command = command_reg;
    assign frame_info.length  = 8'(frame_length_reg);

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SYNC1;
            frame_length_reg <= '0;
            command_reg      <= '0;
            fill_count_reg   <= '0;
            crc_low_reg      <= '0;
            crc_reg          <= CRC_INIT;
        end else begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            command_reg      <= command_next;
            fill_count_reg   <= fill_count_next;
            crc_low_reg      <= crc_low_next;
            crc_reg          <= crc_next;
        end
    end

endmodule

[rtl/core/sfp_emitter.sv]
// Result emitter: walks the payload buffer of a checked frame and streams it out.
module sfp_emitter
    import sfp_pkg::*;
#(
    parameter int LEN_W  = 7,
    parameter int ADDR_W = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  frame_info_t        frame_info,
    output logic               busy,
    output logic               ram_re,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [7:0]         ram_rdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    emit_state_t      state_reg, state_next;
    logic [LEN_W-1:0] addr_reg, addr_next;
    logic             empty_reg, empty_next;

    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] addr_inc;
    logic             is_last;
    logic [7:0]       payload_byte;

    assign frame_len = frame_info.length[LEN_W-1:0];
    assign addr_inc  = addr_reg + LEN_W'(1);
    assign is_last   = empty_reg || (addr_inc == frame_len);

    // Next state, read address and empty-frame flag.
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        empty_next = empty_reg;
        case (state_reg)
            E_IDLE: begin
                if (frame_info.start) begin
                    addr_next  = '0;
                    empty_next = (frame_len == '0);
                    state_next = (frame_len == '0) ? E_SHOW : E_READ;
                end
            end
            E_READ: begin
                state_next = E_SHOW;
            end
            E_SHOW: begin
                if (m_tready) begin
                    if (is_last) begin
                        state_next = E_IDLE;
                    end else begin
                        addr_next  = addr_inc;
                        state_next = E_READ;
                    end
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        ram_re   = 1'b0;
        m_tvalid = 1'b0;
        busy     = 1'b1;
        case (state_reg)
            E_IDLE: begin
                busy = 1'b0;
            end
            E_READ: begin
                ram_re = 1'b1;
            end
            E_SHOW: begin
                m_tvalid = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    assign ram_raddr    = addr_reg[ADDR_W-1:0];
    assign payload_byte = empty_reg ? 8'h00 : ram_rdata;

    // Result transfer: command, length, data byte, zero pad.
    assign m_tdata = {1'b0, payload_byte, frame_info.length[PLEN_W-1:0], frame_info.command};
    assign m_tuser = !empty_reg;
    assign m_tlast = is_last;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            addr_reg  <= '0;
            empty_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            empty_reg <= empty_next;
        end
    end

endmodule

[rtl/core/serial_frame_parser_crc16_unit.sv]
// Top level of the serial frame parser with Modbus CRC16 check.
//
// Received bytes arrive one per input transfer and are parsed as frames of
// 0x55 0xAA LEN CMD DATA[LEN] CRC_L CRC_H; the CRC16 (0xA001, start 0xFFFF)
// covers LEN, CMD and DATA. While a frame is being parsed the block takes one
// byte per cycle. When CRC_H completes a good frame, s_tready drops and the
// frame is sent as LEN result transfers (one per data byte, tlast on the last)
// or one transfer with tuser low for an empty frame. Each data result is read
// from the payload buffer, whose read port is registered, in state E_READ
// and then presented in state E_SHOW until m_tready takes it, so a good
// frame holds the input until its last result is taken. Bad frames give no
// result and do not hold off the input. The payload buffer needs no clearing
// after reset.
module serial_frame_parser_crc16_unit
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = SFP_MAX_PAYLOAD
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] command, [14:8] payload_length,
                                          // [22:15] payload_byte, [23] zero
    output logic               m_tuser,   // [0] has_payload
    output logic               m_tlast
);

    localparam int LenW  = $clog2(MAX_PAYLOAD + 1);
    localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    frame_info_t      frame_info;
    logic             emit_busy;
    logic             byte_accept;
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [AddrW-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    // Input is held off while a checked frame is being sent.
    assign s_tready    = !emit_busy;
    assign byte_accept = s_tvalid && s_tready;

    sfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LenW),
        .ADDR_W      (AddrW)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .frame_info  (frame_info),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    sfp_payload_ram #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (AddrW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfp_emitter #(
        .LEN_W  (LenW),
        .ADDR_W (AddrW)
    ) u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_info (frame_info),
        .busy       (emit_busy),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // A good frame stops the input on the next cycle.
    a_start_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_info.start |=> !s_tready)
        else $error("input still ready after a frame was handed off");

    // Results and input bytes never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("result offered while input is accepted");

    // The buffer is never written and read in the same cycle.
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> !ram_we)
        else $error("payload buffer written during readout");

endmodule

[dv/tb_serial_frame_parser_crc16_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the serial frame parser with Modbus CRC16 check.
module tb_serial_frame_parser_crc16_unit;
    import sfp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_CAP    = 100;

    // Where a directed byte comes from, and how its results are known.
    typedef enum logic [1:0] {
        SRC_LIT     = 2'd0,
        SRC_CRC_LO  = 2'd1,
        SRC_CRC_HI  = 2'd2,
        SRC_CRC_BAD = 2'd3
    } byte_src_t;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_EMPTY = 2'd2
    } row_check_t;

    typedef struct packed {
        byte_src_t  src;
        logic [7:0] value;
        row_check_t chk;
        logic [7:0] cmd;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] cmd;
        logic [6:0] plen;
        logic [7:0] pbyte;
        logic       has;
        logic       last;
    } frame_result_t;

    // Block ports.
    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    // Predictor state, mirroring the parser after reset.
    parse_phase_t rx_phase  = PH_SYNC1;
    logic [6:0]   frm_len   = 7'd0;
    logic [7:0]   frm_cmd   = 8'h00;
    logic [6:0]   fill_cnt  = 7'd0;
    logic [7:0]   crc_lo_rx = 8'h00;
    logic [15:0]  crc_acc   = CRC_INIT;
    logic [7:0]   data_buf [SFP_MAX_PAYLOAD];

    frame_result_t fresh_results [$];
    frame_result_t pending_results [$];
    stim_row_t     directed_rows [$];

    // Bookkeeping.
    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  bytes_sent      = 0;
    int  frames_good     = 0;
    int  frames_bad      = 0;
    int  oversized_cnt   = 0;
    int  sync_breaks     = 0;
    int  cycle_count     = 0;
    int  hold_token      = 0;
    bit  burst_mode      = 1'b0;

    serial_frame_parser_crc16_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Cycle counter with a hard stop.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // One line per mismatch; printing is capped but counting is not.
    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Bitwise reflected CRC16 update, least significant bit first.
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Frame parser prediction: advances on one accepted byte and queues
    // the result transfers that a good CRC high byte releases.
    task automatic parse_rx_byte(input logic [7:0] b);
        frame_result_t res;
        case (rx_phase)
            PH_SYNC2: begin
                if (b == SYNC2_BYTE) begin
                    rx_phase = PH_LEN;
                end else if (b != SYNC1_BYTE) begin
                    rx_phase = PH_SYNC1;
                end
            end
            PH_LEN: begin
                if (b > SFP_MAX_PAYLOAD) begin
                    rx_phase = PH_SYNC1;
                end else begin
                    frm_len  = b[6:0];
                    crc_acc  = crc16_step(crc_acc, b);
                    rx_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                frm_cmd  = b;
                crc_acc  = crc16_step(crc_acc, b);
                rx_phase = (frm_len == 7'd0) ? PH_CRCL : PH_DATA;
            end
            PH_DATA: begin
                if (fill_cnt < frm_len) begin
                    data_buf[fill_cnt[5:0]] = b;
                end
                fill_cnt = fill_cnt + 7'd1;
                crc_acc  = crc16_step(crc_acc, b);
                if (fill_cnt >= frm_len) begin
                    rx_phase = PH_CRCL;
                end
            end
            PH_CRCL: begin
                crc_lo_rx = b;
                rx_phase  = PH_CRCH;
            end
            PH_CRCH: begin
                if ({b, crc_lo_rx} == crc_acc) begin
                    res.cmd  = frm_cmd;
                    res.plen = frm_len;
                    if (frm_len == 7'd0) begin
                        res.pbyte = 8'h00;
                        res.has   = 1'b0;
                        res.last  = 1'b1;
                        fresh_results.push_back(res);
                    end else begin
                        for (int i = 0; i < frm_len; i++) begin
                            res.pbyte = data_buf[i];
                            res.has   = 1'b1;
                            res.last  = (i + 1 == frm_len);
                            fresh_results.push_back(res);
                        end
                    end
                end
                rx_phase = PH_SYNC1;
            end
            default: begin
                rx_phase  = (b == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
                fill_cnt  = 7'd0;
                crc_lo_rx = 8'h00;
                frm_len   = 7'd0;
                frm_cmd   = 8'h00;
                crc_acc   = CRC_INIT;
            end
        endcase
    endtask

    // Sender idle time: none in bursts, otherwise mostly short with a few long gaps.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (burst_mode || p < 70) begin
            return 0;
        end
        if (p < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // Payload lengths: mostly short, some medium, a few at or one below the buffer limit.
    function automatic int pick_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 4) begin
            return SFP_MAX_PAYLOAD;
        end
        if (p < 6) begin
            return SFP_MAX_PAYLOAD - 1;
        end
        if (p < 22) begin
            return $urandom_range(9, 24);
        end
        return $urandom_range(0, 8);
    endfunction

    // Offer one byte, wait for the transfer, then update the prediction.
    // Nothing is driven after the transfer so the caller may continue in the same step.
    task automatic send_byte(input logic [7:0] b, input bit from_model);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        parse_rx_byte(b);
        if (from_model) begin
            foreach (fresh_results[i]) begin
                pending_results.push_back(fresh_results[i]);
            end
        end
        fresh_results.delete();
    endtask

    // One complete frame; the CRC bytes are taken from the predicted running CRC.
    task automatic send_frame(input int len, input bit good, input int extra_sync);
        logic [7:0] cmd;
        logic [7:0] crc_hi;
        int         p;
        p = $urandom_range(0, 9);
        if (p == 0) begin
            cmd = 8'h00;
        end else if (p == 1) begin
            cmd = 8'hFF;
        end else begin
            cmd = 8'($urandom_range(0, 255));
        end
        repeat (extra_sync) send_byte(SYNC1_BYTE, 1'b1);
        send_byte(SYNC1_BYTE, 1'b1);
        send_byte(SYNC2_BYTE, 1'b1);
        send_byte(len[7:0], 1'b1);
        send_byte(cmd, 1'b1);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(crc_acc[7:0], 1'b1);
        crc_hi = crc_acc[15:8];
        if (!good) begin
            crc_hi = crc_hi ^ 8'($urandom_range(1, 255));
        end
        send_byte(crc_hi, 1'b1);
        if (good) begin
            frames_good++;
        end else begin
            frames_bad++;
        end
    endtask

    task automatic add_row(input byte_src_t src, input logic [7:0] value,
                           input row_check_t chk, input logic [7:0] cmd);
        stim_row_t row;
        row.src   = src;
        row.value = value;
        row.chk   = chk;
        row.cmd   = cmd;
        directed_rows.push_back(row);
    endtask

    // Result side: random ready with quiet and stall phases, plus one long hold-off.
    initial begin : receiver
        int stall_left;
        int hold_seen;
        int mode_left;
        int p;
        bit eager;
        stall_left = 0;
        hold_seen  = 0;
        mode_left  = 0;
        eager      = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_token != hold_seen) begin
                hold_seen  = hold_token;
                stall_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(64, 256);
                eager     = ($urandom_range(0, 3) == 0);
            end
            mode_left--;
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (eager) begin
                m_tready <= 1'b1;
            end else begin
                p = $urandom_range(0, 99);
                if (p < 75) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready   <= 1'b0;
                    stall_left = (p < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Compare each result transfer with the oldest expected result.
    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result transfer, tdata %h tuser %b tlast %b",
                                        m_tdata, m_tuser, m_tlast));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[7:0] !== want.cmd) begin
                    flag_mismatch($sformatf("command %h, expected %h", m_tdata[7:0], want.cmd));
                end
                if (m_tdata[14:8] !== want.plen) begin
                    flag_mismatch($sformatf("payload length %0d, expected %0d",
                                            m_tdata[14:8], want.plen));
                end
                if (m_tdata[22:15] !== want.pbyte) begin
                    flag_mismatch($sformatf("payload byte %h, expected %h",
                                            m_tdata[22:15], want.pbyte));
                end
                if (m_tdata[23] !== 1'b0) begin
                    flag_mismatch("tdata pad bit is not zero");
                end
                if (m_tuser !== want.has) begin
                    flag_mismatch($sformatf("has_payload %b, expected %b", m_tuser, want.has));
                end
                if (m_tlast !== want.last) begin
                    flag_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
                end
            end
        end
    end

    // Stimulus: reset, directed table, random frames, drain and verdict.
    initial begin : stimulus
        stim_row_t     row;
        frame_result_t typed;
        logic [7:0]    b;
        int            frame_idx;
        int            random_items;
        int            bytes_at_start;
        int            p;
        bit            noise;
        int            directed_bytes;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle byte, repeated sync, then the largest length byte, which is oversized.
        add_row(SRC_LIT, 8'h00, CHK_NONE, 8'h00);
        add_row(SRC_LIT, SYNC1_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, SYNC1_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, SYNC2_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'hFF, CHK_NONE, 8'h00);
        // Length one above the buffer size is dropped too.
        add_row(SRC_LIT, SYNC1_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, SYNC2_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'h41, CHK_NONE, 8'h00);
        // A stray byte after the first sync breaks the sync.
        add_row(SRC_LIT, SYNC1_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'h13, CHK_NONE, 8'h00);
        // Empty frame with command 0xFF gives one result without payload.
        add_row(SRC_LIT, SYNC1_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, SYNC2_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'h00, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'hFF, CHK_NONE, 8'h00);
        add_row(SRC_CRC_LO, 8'h00, CHK_NONE, 8'h00);
        add_row(SRC_CRC_HI, 8'h00, CHK_EMPTY, 8'hFF);
        // One-byte frame with a corrupted CRC gives nothing.
        add_row(SRC_LIT, SYNC1_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, SYNC2_BYTE, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'h01, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'h00, CHK_NONE, 8'h00);
        add_row(SRC_LIT, 8'hFF, CHK_NONE, 8'h00);
        add_row(SRC_CRC_LO, 8'h00, CHK_NONE, 8'h00);
        add_row(SRC_CRC_BAD, 8'h00, CHK_NONE, 8'h00);
        // Good two-byte frame, checked against the prediction.
        add_row(SRC_LIT, SYNC1_BYTE, CHK_MODEL, 8'h00);
        add_row(SRC_LIT, SYNC2_BYTE, CHK_MODEL, 8'h00);
        add_row(SRC_LIT, 8'h02, CHK_MODEL, 8'h00);
        add_row(SRC_LIT, 8'h80, CHK_MODEL, 8'h00);
        add_row(SRC_LIT, 8'hFF, CHK_MODEL, 8'h00);
        add_row(SRC_LIT, 8'h00, CHK_MODEL, 8'h00);
        add_row(SRC_CRC_LO, 8'h00, CHK_MODEL, 8'h00);
        add_row(SRC_CRC_HI, 8'h00, CHK_MODEL, 8'h00);

        // Walk the directed table.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.src)
                SRC_CRC_LO:  b = crc_acc[7:0];
                SRC_CRC_HI:  b = crc_acc[15:8];
                SRC_CRC_BAD: b = crc_acc[15:8] ^ 8'h80;
                default:     b = row.value;
            endcase
            send_byte(b, row.chk == CHK_MODEL);
            if (row.chk == CHK_EMPTY) begin
                typed.cmd   = row.cmd;
                typed.plen  = 7'd0;
                typed.pbyte = 8'h00;
                typed.has   = 1'b0;
                typed.last  = 1'b1;
                pending_results.push_back(typed);
            end
        end
        directed_bytes = bytes_sent;

        // Random part: mostly well-formed frames, some broken ones and some noise.
        frame_idx    = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            burst_mode     = ($urandom_range(0, 3) == 0);
            bytes_at_start = bytes_sent;
            noise          = 1'b0;

            // Let every expected result come out before going on.
            if (frame_idx == 6 || frame_idx == 30) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end

            p = $urandom_range(0, 99);
            if (frame_idx == 2) begin
                send_frame(SFP_MAX_PAYLOAD, 1'b1, 0);
            end else if (frame_idx == 12) begin
                // Long output hold-off while frames keep coming back to back.
                hold_token <= hold_token + 1;
                burst_mode = 1'b1;
                send_frame(24, 1'b1, 0);
            end else if (frame_idx == 13 || frame_idx == 14) begin
                burst_mode = 1'b1;
                send_frame($urandom_range(1, 6), 1'b1, 0);
            end else if (p < 68) begin
                send_frame(pick_length(), 1'b1,
                           ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
            end else if (p < 78) begin
                send_frame(pick_length(), 1'b0, 0);
            end else if (p < 86) begin
                send_byte(SYNC1_BYTE, 1'b1);
                send_byte(SYNC2_BYTE, 1'b1);
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(8'(SFP_MAX_PAYLOAD + 1), 1'b1);
                end else begin
                    send_byte(8'($urandom_range(SFP_MAX_PAYLOAD + 1, 255)), 1'b1);
                end
                oversized_cnt++;
            end else if (p < 93) begin
                b = 8'($urandom_range(0, 255));
                if (b == SYNC1_BYTE || b == SYNC2_BYTE) begin
                    b = 8'h00;
                end
                send_byte(SYNC1_BYTE, 1'b1);
                send_byte(b, 1'b1);
                sync_breaks++;
            end else begin
                noise = 1'b1;
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b1);
            end

            if (!noise) begin
                random_items += bytes_sent - bytes_at_start;
            end
            frame_idx++;
        end

        // Drain: wait for every expected result, then let the block settle.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_results.size()));
        end

        $display("Summary: %0d bytes sent (%0d from the directed table), %0d results checked.",
                 bytes_sent, directed_bytes, results_checked);
        $display("Summary: %0d good and %0d bad-CRC frames, %0d oversized lengths, %0d %s",
                 frames_good, frames_bad, oversized_cnt, sync_breaks, "sync breaks.");
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sfp_pkg.sv
rtl/core/sfp_payload_ram.sv
rtl/core/sfp_parser.sv
rtl/core/sfp_emitter.sv
rtl/core/serial_frame_parser_crc16_unit.sv
dv/tb_serial_frame_parser_crc16_unit.sv
